// File: design/rhg_pkg.sv
package rhg_pkg;

  localparam int unsigned MaxPacket = 4096;
  localparam int unsigned LenW      = 13;
  localparam int unsigned PosW      = $clog2(MaxPacket);
  localparam int unsigned SampleW   = 16;
  localparam int unsigned DiffW     = SampleW + 1;
  localparam int unsigned FactW     = SampleW + 2;
  localparam int unsigned ProdW     = FactW + SampleW;
  localparam int unsigned FracW     = 8;
  localparam int unsigned ShrW      = ProdW - FracW;
  localparam int unsigned SumW      = ShrW + 1;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned RegIdxW   = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegPacketLength  = 3'd0,
    RegRisePoint     = 3'd1,
    RegRiseSlope     = 3'd2,
    RegUpperLevel    = 3'd3,
    RegFallPoint     = 3'd4,
    RegFallSlope     = 3'd5,
    RegLowerLevel    = 3'd6,
    RegStartDir      = 3'd7
  } reg_idx_e;

  // Live configuration plus write strobes that touch datapath state.
  typedef struct packed {
    logic [LenW-1:0]    eff_len;
    logic [SampleW-1:0] rise_point;
    logic [SampleW-1:0] rise_slope;
    logic [SampleW-1:0] upper_level;
    logic [SampleW-1:0] fall_point;
    logic [SampleW-1:0] fall_slope;
    logic [SampleW-1:0] lower_level;
    logic               len_wr;
    logic               dir_wr;
    logic               dir_wdata;
  } cfg_t;

endpackage

// File: design/rhg_regs.sv
module rhg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rhg_pkg::AddrW-1:0]  paddr,
  input  logic [rhg_pkg::DataW-1:0]  pwdata,
  output logic [rhg_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output rhg_pkg::cfg_t              cfg_o
);

  logic [rhg_pkg::LenW-1:0]    len_q;
  logic [rhg_pkg::SampleW-1:0] rise_point_q, rise_slope_q, upper_q;
  logic [rhg_pkg::SampleW-1:0] fall_point_q, fall_slope_q, lower_q;
  logic                        start_dir_q;
  logic                        wr;
  rhg_pkg::reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = rhg_pkg::reg_idx_e'(paddr[rhg_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= rhg_pkg::LenW'(1);
      rise_point_q <= '0;
      rise_slope_q <= rhg_pkg::SampleW'(256);
      upper_q      <= rhg_pkg::SampleW'(256);
      fall_point_q <= '0;
      fall_slope_q <= rhg_pkg::SampleW'(256);
      lower_q      <= '0;
      start_dir_q  <= 1'b0;
    end else if (wr) begin
      case (idx)
        rhg_pkg::RegPacketLength: len_q        <= pwdata[rhg_pkg::LenW-1:0];
        rhg_pkg::RegRisePoint:    rise_point_q <= pwdata[rhg_pkg::SampleW-1:0];
        rhg_pkg::RegRiseSlope:    rise_slope_q <= pwdata[rhg_pkg::SampleW-1:0];
        rhg_pkg::RegUpperLevel:   upper_q      <= pwdata[rhg_pkg::SampleW-1:0];
        rhg_pkg::RegFallPoint:    fall_point_q <= pwdata[rhg_pkg::SampleW-1:0];
        rhg_pkg::RegFallSlope:    fall_slope_q <= pwdata[rhg_pkg::SampleW-1:0];
        rhg_pkg::RegLowerLevel:   lower_q      <= pwdata[rhg_pkg::SampleW-1:0];
        rhg_pkg::RegStartDir:     start_dir_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rhg_pkg::RegPacketLength: prdata = rhg_pkg::DataW'(len_q);
      rhg_pkg::RegRisePoint:    prdata = rhg_pkg::DataW'(rise_point_q);
      rhg_pkg::RegRiseSlope:    prdata = rhg_pkg::DataW'(rise_slope_q);
      rhg_pkg::RegUpperLevel:   prdata = rhg_pkg::DataW'(upper_q);
      rhg_pkg::RegFallPoint:    prdata = rhg_pkg::DataW'(fall_point_q);
      rhg_pkg::RegFallSlope:    prdata = rhg_pkg::DataW'(fall_slope_q);
      rhg_pkg::RegLowerLevel:   prdata = rhg_pkg::DataW'(lower_q);
      rhg_pkg::RegStartDir:     prdata = rhg_pkg::DataW'(start_dir_q);
      default:                  prdata = '0;
    endcase
  end

  // zero length acts as one, oversize lengths saturate
  always_comb begin
    if (len_q == '0) begin
      cfg_o.eff_len = rhg_pkg::LenW'(1);
    end else if (len_q > rhg_pkg::LenW'(rhg_pkg::MaxPacket)) begin
      cfg_o.eff_len = rhg_pkg::LenW'(rhg_pkg::MaxPacket);
    end else begin
      cfg_o.eff_len = len_q;
    end
  end

  assign cfg_o.rise_point  = rise_point_q;
  assign cfg_o.rise_slope  = rise_slope_q;
  assign cfg_o.upper_level = upper_q;
  assign cfg_o.fall_point  = fall_point_q;
  assign cfg_o.fall_slope  = fall_slope_q;
  assign cfg_o.lower_level = lower_q;
  assign cfg_o.len_wr      = wr && (idx == rhg_pkg::RegPacketLength);
  assign cfg_o.dir_wr      = wr && (idx == rhg_pkg::RegStartDir);
  assign cfg_o.dir_wdata   = pwdata[0];

endmodule

// File: design/ramp_hysteresis_gate.sv
// Hysteresis gate with linear ramps on the difference of a sample pair.
// Input channel: in_valid_i/in_ready_o carry sample_a_i, sample_b_i (Q8.8).
// Output channel: out_valid_o/out_ready_i carry gate_value_o (Q8.8) and
// direction_o (0 forward, 1 backward); exactly one result beat per input beat.
// Configuration goes through the APB port, registers at byte address 4*i.
// Pipeline: input register, product register, result register; a beat
// moves through them in that order. Without stalls, throughput is one beat
// per clock: both ramp products are formed ahead of time, so only the
// select/add/clamp and direction update close the loop.
// The first sample of each packet computes a new value; the rest of the
// packet repeats the held value and direction.
// Reset clears the pipeline, sets the packet position to the start, the held
// value to zero and the direction to forward.
// When out_ready_i is low, the pipeline fills and in_ready_o drops after at
// most three further beats; no beat is lost or repeated.
module ramp_hysteresis_gate (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rhg_pkg::AddrW-1:0]  paddr,
  input  logic [rhg_pkg::DataW-1:0]  pwdata,
  output logic [rhg_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         sample_a_i,
  input  logic signed [15:0]         sample_b_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         gate_value_o,
  output logic                       direction_o
);

  rhg_pkg::cfg_t cfg;

  rhg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline control
  logic v1_q, v2_q, out_valid_q;
  logic free1, free2, free3;
  logic accept, load2, load3;

  assign free3      = !out_valid_q || out_ready_i;
  assign load3      = v2_q && free3;
  assign free2      = !v2_q || free3;
  assign load2      = v1_q && free2;
  assign free1      = !v1_q || free2;
  assign in_ready_o = free1;
  assign accept     = in_valid_i && free1;

  // packet position
  logic [rhg_pkg::PosW-1:0] pos_q, pos_d;
  logic                     last;

  assign last = ({1'b0, pos_q} + rhg_pkg::LenW'(1)) >= cfg.eff_len;

  always_comb begin
    pos_d = pos_q;
    if (cfg.len_wr) begin
      pos_d = '0;
    end else if (accept) begin
      pos_d = last ? '0 : pos_q + rhg_pkg::PosW'(1);
    end
  end

  // stage 1: input register
  logic signed [rhg_pkg::SampleW-1:0] a_q, b_q;
  logic                               first1_q;

  // stage 2: both ramp products
  logic signed [rhg_pkg::DiffW-1:0]   diff;
  logic signed [rhg_pkg::FactW-1:0]   fwd_fact, bwd_fact;
  logic signed [rhg_pkg::ProdW-1:0]   fwd_prod, bwd_prod;
  logic signed [rhg_pkg::ProdW-1:0]   pf_q, pb_q;
  logic                               first2_q;

  assign diff     = rhg_pkg::DiffW'(a_q) - rhg_pkg::DiffW'(b_q);
  assign fwd_fact = rhg_pkg::FactW'(diff) - rhg_pkg::FactW'($signed(cfg.rise_point));
  // backward ramp negates the product; fold that into the factor
  assign bwd_fact = rhg_pkg::FactW'($signed(cfg.fall_point)) - rhg_pkg::FactW'(diff);
  assign fwd_prod = rhg_pkg::ProdW'(fwd_fact) * rhg_pkg::ProdW'($signed(cfg.rise_slope));
  assign bwd_prod = rhg_pkg::ProdW'(bwd_fact) * rhg_pkg::ProdW'($signed(cfg.fall_slope));

  // stage 3: select, floor to Q8.8, add level, clamp
  logic                               dir_q, held_dir;
  logic signed [rhg_pkg::SampleW-1:0] held_q;
  logic signed [rhg_pkg::SampleW-1:0] lo, hi, base, clamped;
  logic signed [rhg_pkg::ProdW-1:0]   sel;
  logic signed [rhg_pkg::ShrW-1:0]    shr;
  logic signed [rhg_pkg::SumW-1:0]    sum;
  logic                               new_dir;
  logic signed [rhg_pkg::SampleW-1:0] gate_d;
  logic                               dir_out_d;
  logic signed [rhg_pkg::SampleW-1:0] gate_q;
  logic                               dir_out_q;

  assign lo   = $signed(cfg.lower_level);
  assign hi   = $signed(cfg.upper_level);
  assign sel  = dir_q ? pb_q : pf_q;
  assign base = dir_q ? hi : lo;
  assign shr  = sel[rhg_pkg::ProdW-1:rhg_pkg::FracW];
  assign sum  = rhg_pkg::SumW'(shr) + rhg_pkg::SumW'(base);

  always_comb begin
    if (sum < rhg_pkg::SumW'(lo)) begin
      clamped = lo;
    end else if (sum > rhg_pkg::SumW'(hi)) begin
      clamped = hi;
    end else begin
      clamped = sum[rhg_pkg::SampleW-1:0];
    end
  end

  assign new_dir   = dir_q ? (clamped != lo) : (clamped == hi);
  assign held_dir  = dir_q;
  assign gate_d    = first2_q ? clamped : held_q;
  assign dir_out_d = first2_q ? new_dir : held_dir;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      dir_q       <= 1'b0;
      held_q      <= '0;
    end else begin
      pos_q <= pos_d;
      if (free1) begin
        v1_q <= in_valid_i;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
      if (free3) begin
        out_valid_q <= v2_q;
      end
      if (cfg.dir_wr) begin
        dir_q <= cfg.dir_wdata;
      end else if (load3 && first2_q) begin
        dir_q  <= new_dir;
      end
      if (load3 && first2_q) begin
        held_q <= clamped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q      <= sample_a_i;
      b_q      <= sample_b_i;
      first1_q <= (pos_q == '0);
    end
    if (load2) begin
      pf_q     <= fwd_prod;
      pb_q     <= bwd_prod;
      first2_q <= first1_q;
    end
    if (load3) begin
      gate_q    <= gate_d;
      dir_out_q <= dir_out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gate_value_o = gate_q;
  assign direction_o  = dir_out_q;

  // packet position always stays inside the effective length
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < cfg.eff_len)
    else $error("packet position out of range");

  // a result beat carries the state left behind by its own sample
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load3 && !cfg.dir_wr |=> (gate_q == held_q) && (dir_out_q == dir_q))
    else $error("result register disagrees with held state");

  // samples past the first of a packet leave the held value alone
  a_hold_mid_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load3 && !first2_q |=> $stable(held_q))
    else $error("held value changed mid packet");

  // with ordered levels a fresh value lands inside them
  a_clamp_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load3 && first2_q && (lo <= hi) |-> (clamped >= lo) && (clamped <= hi))
    else $error("clamped value outside levels");

endmodule
